// ----- src/ds_twr_range_averager_top_defines.svh -----
// Assertion macros for the ranging averager. Each assertion is sampled on the
// rising edge of clk and is disabled while rst_n is low.
`ifndef DS_TWR_RANGE_AVERAGER_TOP_DEFINES_SVH
`define DS_TWR_RANGE_AVERAGER_TOP_DEFINES_SVH

// Checks that prop holds at every sampled edge.
`define DS_TWR_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ds_twr assertion failed");

// Checks that cond is followed by nxt on the next edge.
`define DS_TWR_ASSERT_NEXT(name, cond, nxt) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("ds_twr sequencing assertion failed");

`endif

// ----- src/ds_twr_pkg.sv -----
// ----------------------------------------------------------------------------
// ds_twr_pkg
// Shared constants and types for the two-way ranging distance averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ds_twr_pkg;

    localparam int TS_W    = 40;   // timestamp width
    localparam int HALF_W  = 20;   // multiplier operand width
    localparam int PROD_W  = 80;   // full product width
    localparam int DEN_W   = 42;   // sum of four intervals
    localparam int DIST_W  = 24;
    localparam int AD_W    = 16;
    localparam int MPT_W   = 32;
    localparam int STEP_W  = 7;    // divider step count, up to 80
    localparam int ADDR_W  = 4;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] ST_ACCEPT  = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_NEG     = 2'd2;
    localparam logic [1:0] ST_LIMIT   = 2'd3;

    localparam logic [1:0] REG_ANT_DELAY = 2'd0;
    localparam logic [1:0] REG_MPT       = 2'd1;
    localparam logic [1:0] REG_LIMIT     = 2'd2;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

// ----- src/ds_twr_div.sv -----
// ----------------------------------------------------------------------------
// ds_twr_div
// Restoring divider, one quotient bit per cycle, dividend taken from the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ds_twr_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ds_twr_pkg::div_req_t                req,
    input  logic [ds_twr_pkg::PROD_W-1:0]       dividend,
    input  logic [ds_twr_pkg::DEN_W-1:0]        divisor,
    output logic [ds_twr_pkg::TS_W-1:0]         quotient,
    output logic                                done
);

    logic [ds_twr_pkg::PROD_W-1:0]      num_reg;
    logic [ds_twr_pkg::DEN_W-1:0]       den_reg;
    logic [ds_twr_pkg::DEN_W-1:0]       rem_reg;
    logic [ds_twr_pkg::TS_W-1:0]        quo_reg;
    logic [ds_twr_pkg::STEP_W-1:0]      cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    logic [ds_twr_pkg::DEN_W:0]         rem_shift;
    logic                               rem_ge;
    logic [ds_twr_pkg::DEN_W:0]         rem_sub;

    assign rem_shift = {rem_reg, num_reg[ds_twr_pkg::PROD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ds_twr_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[ds_twr_pkg::PROD_W-2:0], 1'b0};
            rem_reg <= rem_ge ? rem_sub[ds_twr_pkg::DEN_W-1:0]
                              : rem_shift[ds_twr_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[ds_twr_pkg::TS_W-2:0], rem_ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- src/ds_twr_range_averager_top.sv -----
// ----------------------------------------------------------------------------
// ds_twr_range_averager_top
// Double-sided two-way ranging distance with a ring average of recent values.
// ----------------------------------------------------------------------------
// Channel   Role     Contents
// s_*       in       exchange timestamps (tdata), timed_out (tuser)
// m_*       out      distance, average, filled count (tdata), status/flags (tuser)
// p*        config   antenna delay, meters per tick, distance limit
//
// A stored exchange, once the request is taken, runs eight 20x20 partial
// products, a check, an 80-step division, 4 scaling products, ring read,
// store, report setup and output load. Report items add a division of
// 24+log2(RING_DEPTH) steps. s_tready is high only in idle, in the cycle after
// the output load, so a new exchange is taken only after the last is reported.
// A full output register stalls the exchange at its end until m_tready. No
// clearing pass after reset.
`timescale 1ns / 1ps
`include "ds_twr_range_averager_top_defines.svh"

module ds_twr_range_averager_top
#(
    parameter int RING_DEPTH = 64
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // s_tdata: first_tx_time, first_rx_time, peer_reply_time, second_tx_time,
    //          peer_round_time (40 bits each, lowest first)
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [199:0]                           s_tdata,
    // s_tuser: timed_out
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata: distance[24], average_distance[24], filled_entries, zero pad
    output logic [((2 * ds_twr_pkg::DIST_W + $clog2(RING_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                                   m_tdata,
    // m_tuser: status[2], average_valid
    output logic [2:0]                             m_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ds_twr_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = ds_twr_pkg::DIST_W + $clog2(RING_DEPTH);
    localparam int OUT_BITS = 2 * ds_twr_pkg::DIST_W + CNT_W;
    localparam int OUT_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_SCALE = 4'd4;
    localparam logic [3:0] S_SAT   = 4'd5;
    localparam logic [3:0] S_STORE = 4'd6;
    localparam logic [3:0] S_AVGGO = 4'd7;
    localparam logic [3:0] S_AVG   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam int TW = ds_twr_pkg::TS_W;
    localparam int PW = ds_twr_pkg::PROD_W;
    localparam int HW = ds_twr_pkg::HALF_W;
    localparam int DW = ds_twr_pkg::DIST_W;

    // configuration
    logic [ds_twr_pkg::AD_W-1:0]  ant_delay_reg;
    logic [ds_twr_pkg::MPT_W-1:0] mpt_reg;
    logic [DW-1:0]                limit_reg;
    logic                         cfg_wr;

    // control
    logic [3:0]         state_reg;
    logic [2:0]         step_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [SLOT_W-1:0]  phase_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               m_tvalid_reg;

    // datapath
    logic [TW-1:0]      r1_reg, r2_reg, p1_reg, p2_reg;
    logic [PW-1:0]      acc_a_reg, acc_b_reg;
    logic [DW-1:0]      res_dist_reg, res_avg_reg;
    logic [1:0]         res_status_reg;
    logic               res_avgv_reg;
    logic [DW-1:0]      old_reg;
    logic [DW-1:0]      ring_mem [RING_DEPTH];

    logic [OUT_W-1:0]   out_data_reg;
    logic [2:0]         out_user_reg;

    // shared multiplier
    logic [TW-1:0]      op_x, op_y;
    logic [HW-1:0]      mul_a, mul_b;
    logic [2*HW-1:0]    mul_p;
    logic [6:0]         mul_sh;
    logic [PW-1:0]      addend;

    // divider
    ds_twr_pkg::div_req_t div_req;
    logic [PW-1:0]        div_num;
    logic [ds_twr_pkg::DEN_W-1:0] div_den;
    logic [TW-1:0]        div_quo;
    logic                 div_done;

    logic [ds_twr_pkg::DEN_W-1:0] den_sum;
    logic [DW-1:0]      dist_sat;
    logic               ring_full;
    logic               out_free;

    ds_twr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .done     (div_done)
    );

    // ---------------- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ant_delay_reg <= 16'd16436;
            mpt_reg       <= 32'd20151010;
            limit_reg     <= 24'd6553600;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                ds_twr_pkg::REG_ANT_DELAY: ant_delay_reg <= pwdata[15:0];
                ds_twr_pkg::REG_MPT:       mpt_reg       <= pwdata;
                ds_twr_pkg::REG_LIMIT:     limit_reg     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            ds_twr_pkg::REG_ANT_DELAY: prdata = {16'd0, ant_delay_reg};
            ds_twr_pkg::REG_MPT:       prdata = mpt_reg;
            ds_twr_pkg::REG_LIMIT:     prdata = {8'd0, limit_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------- multiplier operand selection
    always_comb
    begin
        op_x   = step_reg[2] ? p1_reg : r1_reg;
        op_y   = step_reg[2] ? p2_reg : r2_reg;
        mul_a  = step_reg[1] ? op_x[TW-1:HW] : op_x[HW-1:0];
        mul_b  = step_reg[0] ? op_y[TW-1:HW] : op_y[HW-1:0];
        mul_sh = (step_reg[1] ? 7'd20 : 7'd0) + (step_reg[0] ? 7'd20 : 7'd0);
        if (state_reg == S_SCALE)
        begin
            mul_a  = step_reg[1] ? div_quo[TW-1:HW] : div_quo[HW-1:0];
            mul_b  = step_reg[0] ? {4'd0, mpt_reg[31:16]} : {4'd0, mpt_reg[15:0]};
            mul_sh = (step_reg[1] ? 7'd20 : 7'd0) + (step_reg[0] ? 7'd16 : 7'd0);
        end
    end

    assign mul_p  = mul_a * mul_b;
    assign addend = {{(PW-2*HW){1'b0}}, mul_p} << mul_sh;

    assign den_sum = {2'd0, r1_reg} + {2'd0, r2_reg} + {2'd0, p1_reg} + {2'd0, p2_reg};
    assign dist_sat = (|acc_a_reg[PW-1:DW+16]) ? ds_twr_pkg::DIST_MAX
                                               : acc_a_reg[DW+15:16];
    assign ring_full = fill_reg == CNT_W'(RING_DEPTH);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.steps = ds_twr_pkg::STEP_W'(PW);
        div_num       = acc_a_reg - acc_b_reg;
        div_den       = den_sum;
        if (state_reg == S_AVGGO)
        begin
            div_req.start = (phase_reg == '0) && (fill_reg != '0);
            div_req.steps = ds_twr_pkg::STEP_W'(SUM_W);
            div_num       = {sum_reg, {(PW-SUM_W){1'b0}}};
            div_den       = {{(ds_twr_pkg::DEN_W-CNT_W){1'b0}}, fill_reg};
        end
        else if (state_reg == S_CHK)
        begin
            div_req.start = (den_sum != '0) && (acc_a_reg >= acc_b_reg);
        end
    end

    // ---------------- ring memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SAT)
            old_reg <= ring_mem[slot_reg];
        if (state_reg == S_STORE)
            ring_mem[slot_reg] <= res_dist_reg;
    end

    // ---------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            phase_reg    <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (s_tvalid)
                        state_reg <= s_tuser[0] ? S_AVGGO : S_MUL;
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd7)
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    state_reg <= div_req.start ? S_DIV : S_AVGGO;
                end
                S_DIV:
                begin
                    step_reg <= '0;
                    if (div_done)
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd3)
                        state_reg <= S_SAT;
                end
                S_SAT:
                begin
                    state_reg <= (dist_sat < limit_reg) ? S_STORE : S_AVGGO;
                end
                S_STORE:
                begin
                    if (ring_full)
                        sum_reg <= sum_reg - SUM_W'(old_reg) + SUM_W'(res_dist_reg);
                    else
                    begin
                        sum_reg  <= sum_reg + SUM_W'(res_dist_reg);
                        fill_reg <= fill_reg + 1'b1;
                    end
                    slot_reg  <= (slot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                      : slot_reg + 1'b1;
                    state_reg <= S_AVGGO;
                end
                S_AVGGO:
                begin
                    phase_reg <= (phase_reg == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                       : phase_reg + 1'b1;
                    state_reg <= div_req.start ? S_AVG : S_DONE;
                end
                S_AVG:
                begin
                    if (div_done)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------- datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                r1_reg <= s_tdata[79:40] - s_tdata[39:0]
                          - {{(TW-ds_twr_pkg::AD_W){1'b0}}, ant_delay_reg};
                p1_reg <= s_tdata[119:80];
                p2_reg <= s_tdata[159:120] - s_tdata[79:40]
                          + {{(TW-ds_twr_pkg::AD_W){1'b0}}, ant_delay_reg};
                r2_reg <= s_tdata[199:160];
                acc_a_reg      <= '0;
                acc_b_reg      <= '0;
                res_dist_reg   <= '0;
                res_avg_reg    <= '0;
                res_avgv_reg   <= 1'b0;
                res_status_reg <= ds_twr_pkg::ST_TIMEOUT;
            end
            S_MUL:
            begin
                if (step_reg[2])
                    acc_b_reg <= acc_b_reg + addend;
                else
                    acc_a_reg <= acc_a_reg + addend;
            end
            S_CHK:
            begin
                res_status_reg <= ds_twr_pkg::ST_NEG;
                acc_a_reg      <= '0;
            end
            S_SCALE:
            begin
                acc_a_reg <= acc_a_reg + addend;
            end
            S_SAT:
            begin
                res_dist_reg   <= dist_sat;
                res_status_reg <= (dist_sat < limit_reg) ? ds_twr_pkg::ST_ACCEPT
                                                         : ds_twr_pkg::ST_LIMIT;
            end
            S_AVGGO:
            begin
                res_avgv_reg <= phase_reg == '0;
            end
            S_AVG:
            begin
                res_avg_reg <= div_quo[DW-1:0];
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= OUT_W'({fill_reg, res_avg_reg, res_dist_reg});
                    out_user_reg <= {res_avgv_reg, res_status_reg};
                end
            end
            default: ;
        endcase
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ---------------- assertions
    `DS_TWR_ASSERT(a_fill_bound, fill_reg <= CNT_W'(RING_DEPTH))
    `DS_TWR_ASSERT_NEXT(a_store_nonempty, state_reg == S_STORE, fill_reg != '0)
    `DS_TWR_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg != S_IDLE)
    `DS_TWR_ASSERT(a_avg_zero, (m_tvalid && !m_tuser[2]) |-> (m_tdata[47:24] == '0))

endmodule
